// ===== rtl/rc6_pkg.sv =====
// Package: types, constants and helper functions for the RC6 cipher core.
`timescale 1ns / 1ps
package rc6_pkg;

  localparam int unsigned ROUNDS_DEF = 20;
  localparam logic [31:0] P32 = 32'hB7E15163;
  localparam logic [31:0] Q32 = 32'h9E3779B9;
  localparam int unsigned LGW = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    ACT_ENC = 2'd0,
    ACT_DEC = 2'd1,
    ACT_EXP = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOKEY  = 2'd1,
    ST_BADLEN = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KLEN = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [31:0] out_d;
    logic [1:0]  status;
  } out_beat_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOADKEY,   // copy key words from configuration
    OP_INITRK,    // write one P/Q table entry
    OP_MIX,       // one key mixing step
    OP_RDPRE,     // read whitening key
    OP_ENCPRE,
    OP_ENCRND,
    OP_ENCPOST,
    OP_DECPRE,
    OP_DECRND,
    OP_DECPOST,
    OP_CLEAR      // zero the block words
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [6:0] rk_addr;   // table entry read
    logic [6:0] rk_waddr;
    logic       capture;   // load input words
  } dp_cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

// ===== rtl/rc6_datapath.sv =====
// Datapath: block registers, key mixing registers and the round-key memory.
`timescale 1ns / 1ps
module rc6_datapath
  import rc6_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic        clk,
  input  dp_cmd_t     cmd,
  input  in_beat_t    in_data,
  input  logic [255:0] key_bits,
  input  logic [2:0]  nwords_m1,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);
  localparam int unsigned NUM_RK = 2 * ROUNDS + 4;

  logic [31:0] rk_mem [NUM_RK];
  logic [31:0] rk_q_r;
  logic [31:0] kw_r [8];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] ma_r, mb_r;
  logic [2:0]  j_r;

  // Staged round math: f(b) and f(d) registered before use.
  logic [31:0] t_r, u_r;
  logic [31:0] fb, fd, sum_a, new_a, sum_b, fb2, fd2;

  always_comb begin
    fb = b_r * {b_r[30:0], 1'b1};
    fd = d_r * {d_r[30:0], 1'b1};
    fb2 = rotl32(fb, 5'd5);
    fd2 = rotl32(fd, 5'd5);
    sum_a = rk_q_r + ma_r + mb_r;
    new_a = rotl32(sum_a, 5'(LGW));
    sum_b = new_a + mb_r;
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    rk_q_r <= rk_mem[cmd.rk_addr[$clog2(NUM_RK)-1:0]];
    unique case (cmd.op)
      OP_INITRK: rk_mem[cmd.rk_waddr[$clog2(NUM_RK)-1:0]] <=
                   P32 + Q32 * 32'(cmd.rk_waddr);
      OP_MIX:    rk_mem[cmd.rk_waddr[$clog2(NUM_RK)-1:0]] <= new_a;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r <= fb2;
    u_r <= fd2;
    if (cmd.capture) begin
      a_r <= in_data.word_a;
      b_r <= in_data.word_b;
      c_r <= in_data.word_c;
      d_r <= in_data.word_d;
    end
    unique case (cmd.op)
      OP_LOADKEY: begin
        for (int k = 0; k < 8; k++) begin
          kw_r[k] <= (3'(k) <= nwords_m1) ? key_bits[32*k +: 32] : 32'd0;
        end
        ma_r <= '0;
        mb_r <= '0;
        j_r  <= '0;
      end
      OP_MIX: begin
        ma_r <= new_a;
        mb_r <= rotl32(kw_r[j_r] + sum_b, sum_b[4:0]);
        kw_r[j_r] <= rotl32(kw_r[j_r] + sum_b, sum_b[4:0]);
        j_r <= (j_r == nwords_m1) ? 3'd0 : j_r + 3'd1;
      end
      OP_ENCPRE: begin
        // rk_q_r alternates: first cycle S[0] arrives, handled by controller timing
        if (cmd.rk_waddr[0]) d_r <= d_r + rk_q_r;
        else b_r <= b_r + rk_q_r;
      end
      OP_ENCRND: begin
        // rk_waddr[1:0]=0: t/u latch cycle; 1: A update with S[2r]; 2: C update with S[2r+1] and rotate
        unique case (cmd.rk_waddr[1:0])
          2'd1: a_r <= rotl32(a_r ^ t_r, u_r[4:0]) + rk_q_r;
          2'd2: begin
            a_r <= b_r;
            b_r <= rotl32(c_r ^ u_r, t_r[4:0]) + rk_q_r;
            c_r <= d_r;
            d_r <= a_r;
          end
          default: ;
        endcase
      end
      OP_ENCPOST: begin
        if (cmd.rk_waddr[0]) c_r <= c_r + rk_q_r;
        else a_r <= a_r + rk_q_r;
      end
      OP_DECPRE: begin
        if (cmd.rk_waddr[0]) c_r <= c_r - rk_q_r;
        else a_r <= a_r - rk_q_r;
      end
      OP_DECRND: begin
        unique case (cmd.rk_waddr[1:0])
          2'd0: begin
            a_r <= d_r; b_r <= a_r; c_r <= b_r; d_r <= c_r;
          end
          2'd2: c_r <= rotr32(c_r - rk_q_r, t_r[4:0]) ^ u_r;
          2'd3: a_r <= rotr32(a_r - rk_q_r, u_r[4:0]) ^ t_r;
          default: ;
        endcase
      end
      OP_DECPOST: begin
        if (cmd.rk_waddr[0]) d_r <= d_r - rk_q_r;
        else b_r <= b_r - rk_q_r;
      end
      OP_CLEAR: begin
        a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0;
      end
      default: ;
    endcase
  end

  assign a_o = a_r;
  assign b_o = b_r;
  assign c_o = c_r;
  assign d_o = d_r;
endmodule

// ===== rtl/rc6_control.sv =====
// Controller: sequences key expansion, encryption and decryption steps.
`timescale 1ns / 1ps
module rc6_control
  import rc6_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] action,
  input  logic [5:0] key_len,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done,
  output status_t    status
);
  localparam int unsigned NUM_RK = 2 * ROUNDS + 4;
  localparam logic [6:0] LAST_RK = 7'(NUM_RK - 1);
  localparam logic [7:0] MIX_STEPS = 8'(3 * NUM_RK);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_MIXRD, S_MIX, S_PRE, S_RND, S_POST, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       dec_r, dec_nxt;
  logic       key_ready_r, key_ready_nxt;
  logic       done_r, done_nxt;
  status_t    status_r, status_nxt;
  dp_cmd_t    c;
  logic [6:0] mi_r, mi_nxt;
  logic [7:0] mix_last;

  // The mixing runs 3*max(key words, table size) steps; the key words only win
  // for the smallest round counts.
  assign mix_last = (8'(key_len[5:2]) > 8'(NUM_RK)) ?
                    8'(3 * key_len[5:2]) - 8'd1 : MIX_STEPS - 8'd1;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; rnd_nxt = rnd_r; ph_nxt = ph_r;
    dec_nxt = dec_r; key_ready_nxt = key_ready_r; done_nxt = 1'b0;
    status_nxt = status_r; mi_nxt = mi_r;
    c = '{op: OP_IDLE, rk_addr: 7'd0, rk_waddr: 7'd0, capture: 1'b0};
    unique case (state_r)
      S_IDLE: if (start) begin
        c.capture = 1'b1;
        status_nxt = ST_OK;
        unique case (action_t'(action))
          ACT_ENC, ACT_DEC: begin
            if (!key_ready_r) begin
              status_nxt = ST_NOKEY; state_nxt = S_DONE; c.capture = 1'b0;
            end else begin
              dec_nxt = (action == ACT_DEC);
              ph_nxt = 2'd0; state_nxt = S_PRE;
              c.rk_addr = (action == ACT_DEC) ? 7'(2*ROUNDS+2) : 7'd0;
            end
          end
          ACT_EXP: begin
            if (key_len == 6'd16 || key_len == 6'd24 || key_len == 6'd32) begin
              c.op = OP_LOADKEY; cnt_nxt = '0; state_nxt = S_INIT;
            end else begin
              status_nxt = ST_BADLEN; state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_INIT: begin
        c.op = OP_INITRK; c.rk_waddr = cnt_r[6:0];
        if (cnt_r[6:0] == LAST_RK) begin
          cnt_nxt = '0; mi_nxt = '0; state_nxt = S_MIXRD;
        end else cnt_nxt = cnt_r + 8'd1;
      end
      S_MIXRD: begin
        c.rk_addr = mi_r; state_nxt = S_MIX;
      end
      S_MIX: begin
        c.op = OP_MIX; c.rk_waddr = mi_r;
        mi_nxt = (mi_r == LAST_RK) ? 7'd0 : mi_r + 7'd1;
        if (cnt_r == mix_last) begin
          key_ready_nxt = 1'b1; state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 8'd1; state_nxt = S_MIXRD;
        end
      end
      S_PRE: begin
        // The first whitening key was addressed in the previous cycle; apply it
        // and read the second.
        c.op = dec_r ? OP_DECPRE : OP_ENCPRE;
        c.rk_waddr = {6'd0, ph_r[0]};
        c.rk_addr = dec_r ? 7'(2*ROUNDS+3) : 7'd1;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          rnd_nxt = dec_r ? 7'(ROUNDS) : 7'd1;
          state_nxt = S_RND;
          c.rk_addr = dec_r ? 7'(2*ROUNDS+1) : 7'd2;
        end
      end
      S_RND: begin
        if (!dec_r) begin
          // ph0: f latched; ph1: A with S[2r], ph2: rotate with S[2r+1]
          c.op = OP_ENCRND; c.rk_waddr = {5'd0, ph_r};
          c.rk_addr = (ph_r == 2'd0) ? {rnd_r[5:0], 1'b0} : {rnd_r[5:0], 1'b1};
          if (ph_r == 2'd0) c.op = OP_IDLE;
          if (ph_r == 2'd2) begin
            ph_nxt = 2'd0;
            c.rk_addr = {rnd_r[5:0] + 6'd1, 1'b0};
            if (rnd_r == 7'(ROUNDS)) begin
              state_nxt = S_POST; c.rk_addr = 7'(2*ROUNDS+2);
            end
            rnd_nxt = rnd_r + 7'd1;
          end else ph_nxt = ph_r + 2'd1;
        end else begin
          // ph0 rotate, ph1 f latch, ph2 C with S[2r+1], ph3 A with S[2r]
          c.op = OP_DECRND; c.rk_waddr = {5'd0, ph_r};
          c.rk_addr = (ph_r == 2'd2) ? {rnd_r[5:0], 1'b0} : {rnd_r[5:0], 1'b1};
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd3) begin
            c.rk_addr = {rnd_r[5:0] - 6'd1, 1'b1};
            if (rnd_r == 7'd1) begin
              state_nxt = S_POST; c.rk_addr = 7'd0;
            end
            rnd_nxt = rnd_r - 7'd1;
          end
        end
      end
      S_POST: begin
        // Same pattern as the pre-whitening: apply the key read last cycle.
        c.op = dec_r ? OP_DECPOST : OP_ENCPOST;
        c.rk_waddr = {6'd0, ph_r[0]};
        c.rk_addr = dec_r ? 7'd1 : 7'(2*ROUNDS+3);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0; state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status_r != ST_OK || action_t'(action) == ACT_EXP ||
            action_t'(action) == ACT_NOP) c.op = OP_CLEAR;
        state_nxt = S_IDLE;
        done_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic       clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; key_ready_r <= 1'b0; done_r <= 1'b0;
      status_r <= ST_OK; cnt_r <= '0; rnd_r <= '0; ph_r <= '0; dec_r <= 1'b0;
      mi_r <= '0; clr_r <= 1'b0;
    end else begin
      state_r <= state_nxt; key_ready_r <= key_ready_nxt; done_r <= done_nxt;
      status_r <= status_nxt; cnt_r <= cnt_nxt; rnd_r <= rnd_nxt;
      ph_r <= ph_nxt; dec_r <= dec_nxt; mi_r <= mi_nxt;
      if (state_r == S_IDLE && start) begin
        clr_r <= !(action == ACT_ENC || action == ACT_DEC) || !key_ready_r;
      end
    end
  end

  always_comb begin
    cmd = c;
    if (state_r == S_DONE) cmd.op = clr_r ? OP_CLEAR : OP_IDLE;
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = done_r;
  assign status = status_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(state_r == S_DONE);
  endproperty
  a_done: assert property (p_done_after_busy) else $error("done without finish");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy) else $error("start not taken");

  a_key_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(key_ready_r) |-> $past(state_r == S_MIX)) else $error("key ready early");
endmodule

// ===== rtl/rc6_block_cipher_core.sv =====
// Top level of the RC6-32 block cipher core with on-chip key schedule.
`timescale 1ns / 1ps
// Channel  | Ports                         | Handshake
// input    | start, busy, in_data          | beat taken when start && !busy
// result   | out_valid, out_data           | one-cycle strobe, no stall
// config   | cfg_we, cfg_index, cfg_data   | write when cfg_we is high
//
// From the accepting edge, a cipher beat passes the pre-whitening, the rounds, the
// post-whitening, a finish state and the strobe; the pace of each round is set by
// the single registered round-key read and the staged f(). Key expansion writes
// each table entry, then runs the mixing steps, each a read and a mix. A refused
// beat or a no-op goes straight to the finish state.
// A new beat can be taken in the strobe cycle.
// Reset clears control state and key_ready; the round-key memory is not
// cleared. The result strobe is one cycle; the receiver cannot stall it.
module rc6_block_cipher_core
  import rc6_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  logic [63:0] key_r [4];
  logic [5:0]  klen_r;
  dp_cmd_t     cmd;
  logic        done;
  status_t     status;
  logic [31:0] a, b, c, d;
  logic [255:0] key_bits;
  logic [2:0]  nwords_m1;

  // Configuration registers: plain write port, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0; key_r[1] <= '0; key_r[2] <= '0; key_r[3] <= '0;
      klen_r <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0: key_r[0] <= cfg_data;
        REG_KEY1: key_r[1] <= cfg_data;
        REG_KEY2: key_r[2] <= cfg_data;
        REG_KEY3: key_r[3] <= cfg_data;
        REG_KLEN: klen_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign key_bits  = {key_r[3], key_r[2], key_r[1], key_r[0]};
  assign nwords_m1 = 3'((klen_r >> 2) - 6'd1);

  rc6_control #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk, .rst_n, .start, .action(in_data.action), .key_len(klen_r),
    .cmd, .busy, .done, .status
  );

  rc6_datapath #(.ROUNDS(ROUNDS)) u_dp (
    .clk, .cmd, .in_data, .key_bits, .nwords_m1,
    .a_o(a), .b_o(b), .c_o(c), .d_o(d)
  );

  // After a clear in the final cycle the words are zero when done strobes.
  assign out_valid = done;
  assign out_data  = '{out_a: a, out_b: b, out_c: c, out_d: d, status: status};
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the RC6 block cipher core.
`timescale 1ns / 1ps

// Keeps its own copy of the key registers, the key table and the key-ready flag.
// It works out the result of every accepted beat and compares results in order.
class rc6_scoreboard;
  localparam int NRK = 2 * rc6_pkg::ROUNDS_DEF + 4;

  bit [63:0]         key_reg[4];
  bit [5:0]          key_len;
  bit [31:0]         rk[NRK];
  bit [31:0]         kw[8];
  bit                have_key;
  rc6_pkg::out_beat_t pending_q[$];
  bit [31:0]         last_cipher[4];
  int                errors;
  int                n_checked;
  int                n_enc, n_dec, n_exp, n_badlen, n_nokey, n_nop;

  function new();
    key_len  = 16;
    have_key = 0;
    errors   = 0;
  endfunction

  function bit [31:0] rotl(bit [31:0] x, bit [31:0] n);
    n = n & 31;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function bit [31:0] rotr(bit [31:0] x, bit [31:0] n);
    n = n & 31;
    if (n == 0) return x;
    return (x >> n) | (x << (32 - n));
  endfunction

  function bit [31:0] quad_rot(bit [31:0] x);
    bit [31:0] p;
    p = x * (2 * x + 1);
    return rotl(p, 5);
  endfunction

  function void write_reg(bit [2:0] idx, bit [63:0] v);
    if (idx == rc6_pkg::REG_KLEN) key_len = v[5:0];
    else if (idx < rc6_pkg::REG_KLEN) key_reg[idx] = v;
  endfunction

  function void schedule_key(int nbytes);
    int nwords, i, j;
    bit [31:0] a, b;
    nwords = nbytes / 4;
    a = 0;
    b = 0;
    foreach (kw[k]) kw[k] = 0;
    for (int k = 0; k < nbytes; k++)
      kw[k >> 2][8 * (k & 3) +: 8] = key_reg[k >> 3][8 * (k & 7) +: 8];
    rk[0] = rc6_pkg::P32;
    for (int k = 1; k < NRK; k++) rk[k] = rk[k - 1] + rc6_pkg::Q32;
    i = 0;
    j = 0;
    for (int s = 0; s < 3 * NRK; s++) begin
      rk[i] = rotl(rk[i] + a + b, 3);
      a = rk[i];
      kw[j] = rotl(kw[j] + a + b, a + b);
      b = kw[j];
      i = (i + 1 == NRK) ? 0 : i + 1;
      j = (j + 1 == nwords) ? 0 : j + 1;
    end
    have_key = 1;
  endfunction

  function void cipher_fwd(inout bit [31:0] w[4]);
    bit [31:0] a, b, c, d, t, u, tmp;
    a = w[0];
    b = w[1] + rk[0];
    c = w[2];
    d = w[3] + rk[1];
    for (int r = 1; r <= rc6_pkg::ROUNDS_DEF; r++) begin
      t = quad_rot(b);
      u = quad_rot(d);
      a = rotl(a ^ t, u) + rk[2 * r];
      c = rotl(c ^ u, t) + rk[2 * r + 1];
      tmp = a; a = b; b = c; c = d; d = tmp;
    end
    w[0] = a + rk[NRK - 2];
    w[1] = b;
    w[2] = c + rk[NRK - 1];
    w[3] = d;
  endfunction

  function void cipher_inv(inout bit [31:0] w[4]);
    bit [31:0] a, b, c, d, t, u, tmp;
    a = w[0] - rk[NRK - 2];
    b = w[1];
    c = w[2] - rk[NRK - 1];
    d = w[3];
    for (int r = rc6_pkg::ROUNDS_DEF; r >= 1; r--) begin
      tmp = d; d = c; c = b; b = a; a = tmp;
      u = quad_rot(d);
      t = quad_rot(b);
      c = rotr(c - rk[2 * r + 1], t) ^ u;
      a = rotr(a - rk[2 * r], u) ^ t;
    end
    w[0] = a;
    w[1] = b - rk[0];
    w[2] = c;
    w[3] = d - rk[1];
  endfunction

  function void note_input(rc6_pkg::in_beat_t beat);
    rc6_pkg::out_beat_t res;
    bit [31:0] w[4];
    w = '{beat.word_a, beat.word_b, beat.word_c, beat.word_d};
    res.status = rc6_pkg::ST_OK;
    case (rc6_pkg::action_t'(beat.action))
      rc6_pkg::ACT_ENC, rc6_pkg::ACT_DEC: begin
        if (!have_key) begin
          res.status = rc6_pkg::ST_NOKEY;
          w = '{0, 0, 0, 0};
          n_nokey++;
        end else if (beat.action == rc6_pkg::ACT_ENC) begin
          cipher_fwd(w);
          last_cipher = w;
          n_enc++;
        end else begin
          cipher_inv(w);
          n_dec++;
        end
      end
      rc6_pkg::ACT_EXP: begin
        if (key_len == 16 || key_len == 24 || key_len == 32) begin
          schedule_key(key_len);
          n_exp++;
        end else begin
          res.status = rc6_pkg::ST_BADLEN;
          n_badlen++;
        end
        w = '{0, 0, 0, 0};
      end
      default: begin
        w = '{0, 0, 0, 0};
        n_nop++;
      end
    endcase
    res.out_a = w[0];
    res.out_b = w[1];
    res.out_c = w[2];
    res.out_d = w[3];
    pending_q.push_back(res);
  endfunction

  function void check_result(rc6_pkg::out_beat_t got);
    rc6_pkg::out_beat_t exp_r;
    if (pending_q.size() == 0) begin
      $error("result beat with nothing expected: %h", got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    n_checked++;
    if (got.out_a !== exp_r.out_a) begin
      $error("out_a: expected %h, got %h", exp_r.out_a, got.out_a); errors++;
    end
    if (got.out_b !== exp_r.out_b) begin
      $error("out_b: expected %h, got %h", exp_r.out_b, got.out_b); errors++;
    end
    if (got.out_c !== exp_r.out_c) begin
      $error("out_c: expected %h, got %h", exp_r.out_c, got.out_c); errors++;
    end
    if (got.out_d !== exp_r.out_d) begin
      $error("out_d: expected %h, got %h", exp_r.out_d, got.out_d); errors++;
    end
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
    end
  endfunction
endclass

module testbench;
  import rc6_pkg::*;

  // A key expansion is the slowest operation; the watchdog allows many times its
  // length with no beat moving on either side.
  localparam int STALL_LIMIT = 20000;
  localparam int TOTAL_ITEMS = 650;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_beat_t              in_data;
  logic                  out_valid;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rc6_scoreboard cipher_sb;
  int            beats_sent;
  int            quiet_cycles;
  int            n_key_settings;

  rc6_block_cipher_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result beats are a one-cycle strobe. The values seen at the edge are
  // those of the cycle that it closes, so the check has no race with the core.
  always @(posedge clk) begin
    if (rst_n && out_valid) cipher_sb.check_result(out_data);
  end

  // The watchdog counts cycles in which neither channel moved a beat.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("[rc6_block_cipher_core] ERROR");
        $finish;
      end
    end
  end

  // Drops start for a burst of idle cycles. It is the only place that lowers
  // start during the run, so start is never lowered and raised in one step.
  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Presents one beat and holds it until the core takes it.
  task automatic send_beat(action_t act, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
    in_beat_t beat;
    beat.action = act;
    beat.word_a = a;
    beat.word_b = b;
    beat.word_c = c;
    beat.word_d = d;
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    cipher_sb.note_input(beat);
    beats_sent++;
    // Random idle bursts stop in the last part of the run.
    if (beats_sent < TOTAL_ITEMS - 90 && $urandom_range(0, 3) == 0)
      pause_sender($urandom_range(1, 14));
  endtask

  // Holds the sender off until the core has answered every beat and is idle.
  task automatic drain_core();
    pause_sender(1);
    while (cipher_sb.pending_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all five configuration registers back to back, only while idle.
  task automatic load_key_regs(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                               logic [63:0] k3, logic [5:0] len);
    logic [63:0] vals[5];
    vals = '{k0, k1, k2, k3, {58'd0, len}};
    drain_core();
    for (int r = 0; r < 5; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
      cipher_sb.write_reg(CFG_IDX_W'(r), vals[r]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_key_settings++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly valid lengths; now and then a random one, usually rejected.
  function automatic logic [5:0] pick_len();
    case ($urandom_range(0, 9))
      0, 1, 2: return 6'd16;
      3, 4, 5: return 6'd24;
      6, 7, 8: return 6'd32;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    int   phase_items;
    int   pick;
    logic [31:0] r[4];

    cipher_sb      = new();
    beats_sent     = 0;
    quiet_cycles   = 0;
    n_key_settings = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Before any expansion the core must refuse to cipher.
    send_beat(ACT_ENC, '1, '1, '1, '1);
    send_beat(ACT_DEC, '0, '0, '0, '0);
    send_beat(ACT_NOP, '1, '1, '1, '1);
    // Expanding the reset key (all zero bytes, 16 byte length) is legal.
    send_beat(ACT_EXP, '1, '1, '1, '1);
    send_beat(ACT_ENC, '0, '0, '0, '0);
    send_beat(ACT_ENC, '1, '1, '1, '1);
    send_beat(ACT_DEC, '0, '0, '0, '0);
    send_beat(ACT_DEC, '1, '1, '1, '1);

    // A rejected length must leave the old table and key-ready flag alone.
    load_key_regs('1, '1, '1, '1, 6'd0);
    send_beat(ACT_EXP, '0, '0, '0, '0);
    send_beat(ACT_ENC, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'hffff_fffe);
    load_key_regs('1, '1, '1, '1, 6'd63);
    send_beat(ACT_EXP, '0, '0, '0, '0);
    load_key_regs('1, '1, '1, '1, 6'd20);
    send_beat(ACT_EXP, '0, '0, '0, '0);

    // Longest key with every byte set, then a round trip through it.
    load_key_regs('1, '1, '1, '1, 6'd32);
    send_beat(ACT_EXP, '0, '0, '0, '0);
    send_beat(ACT_ENC, '0, '0, '0, '0);
    send_beat(ACT_DEC, cipher_sb.last_cipher[0], cipher_sb.last_cipher[1],
              cipher_sb.last_cipher[2], cipher_sb.last_cipher[3]);
    send_beat(ACT_ENC, '1, '1, '1, '1);
    send_beat(ACT_NOP, '0, '0, '0, '0);
    load_key_regs(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                  64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 6'd24);
    send_beat(ACT_EXP, '0, '0, '0, '0);
    send_beat(ACT_ENC, 32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c);
    send_beat(ACT_DEC, '1, '0, '1, '0);

    // Random part: each phase loads a fresh key and usually expands it first,
    // so that most beats reach the rounds with random data.
    while (beats_sent < TOTAL_ITEMS) begin
      load_key_regs(rand64(), rand64(), rand64(), rand64(), pick_len());
      if ($urandom_range(0, 7) != 0) send_beat(ACT_EXP, $urandom(), $urandom(),
                                               $urandom(), $urandom());
      phase_items = $urandom_range(40, 110);
      for (int n = 0; n < phase_items && beats_sent < TOTAL_ITEMS; n++) begin
        foreach (r[k]) r[k] = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 40) send_beat(ACT_ENC, r[0], r[1], r[2], r[3]);
        else if (pick < 68) send_beat(ACT_DEC, r[0], r[1], r[2], r[3]);
        else if (pick < 88)
          send_beat(ACT_DEC, cipher_sb.last_cipher[0], cipher_sb.last_cipher[1],
                    cipher_sb.last_cipher[2], cipher_sb.last_cipher[3]);
        else if (pick < 93) send_beat(ACT_EXP, r[0], r[1], r[2], r[3]);
        else if (pick < 97) send_beat(ACT_NOP, r[0], r[1], r[2], r[3]);
        else drain_core();
      end
    end

    // Wait for the last answers; the watchdog bounds this loop.
    drain_core();
    repeat (200) @(posedge clk);

    $display("Covered %0d beats over %0d key settings: %0d encrypts, %0d decrypts,",
             beats_sent, n_key_settings, cipher_sb.n_enc, cipher_sb.n_dec);
    $display("%0d expansions, %0d bad lengths, %0d refusals for no key, %0d no-ops.",
             cipher_sb.n_exp, cipher_sb.n_badlen, cipher_sb.n_nokey, cipher_sb.n_nop);
    if (cipher_sb.errors == 0 && cipher_sb.pending_q.size() == 0) begin
      $display("[rc6_block_cipher_core] OK");
    end else begin
      $display("[rc6_block_cipher_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rc6_pkg.sv
rtl/rc6_datapath.sv
rtl/rc6_control.sv
rtl/rc6_block_cipher_core.sv
bench/testbench.sv
